// ----- design/uart_tx_rx_ring_buffers_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef UART_TX_RX_RING_BUFFERS_MACROS_SVH
`define UART_TX_RX_RING_BUFFERS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uart ring buffers: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uart ring buffers: next-cycle check failed");

`endif

// ----- design/uart_trb_pkg.sv -----
`timescale 1ns / 1ps

package uart_trb_pkg;

    localparam int TX_DEPTH_DEF = 64;
    localparam int RX_DEPTH_DEF = 64;

    // Fill counts cover depths up to 255.
    localparam int FILL_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int COUNT_MAX  = 127;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [2:0] {
        OP_SEND     = 3'd0,
        OP_GET      = 3'd1,
        OP_TX_READY = 3'd2,
        OP_RX_BYTE  = 3'd3,
        OP_FLUSH    = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_ENABLE = 1'b0,
        CFG_RX_ENABLE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data;
        logic       hw_tx_ready;
        logic       hw_rx_ready;
        logic [7:0] hw_rx_byte;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic               read_valid;
        logic [7:0]         read_data;
        logic               hw_rx_taken;
        logic               line_write;
        logic [7:0]         line_byte;
        logic               rx_dropped;
        logic               tx_irq_request;
        logic [COUNT_W-1:0] tx_count;
        logic [COUNT_W-1:0] rx_count;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
        logic       clear;
    } ring_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic              empty_next;
        logic [FILL_W-1:0] fill_next;
        logic [7:0]        head;
    } ring_stat_t;

endpackage

// ----- design/uart_trb_in_if.sv -----
`timescale 1ns / 1ps

interface uart_trb_in_if;
    import uart_trb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- design/uart_trb_out_if.sv -----
`timescale 1ns / 1ps

interface uart_trb_out_if;
    import uart_trb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- design/uart_trb_ring.sv -----
`timescale 1ns / 1ps

module uart_trb_ring #(
    parameter int DEPTH = uart_trb_pkg::TX_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  uart_trb_pkg::ring_ctrl_t ctrl,
    output uart_trb_pkg::ring_stat_t stat
);
    import uart_trb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] wr_adv;
    logic [7:0]       head_reg;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_adv = adv(wr_reg);

    always_comb
    begin
        if (ctrl.clear)
        begin
            rd_next = '0;
            wr_next = '0;
        end
        else
        begin
            rd_next = ctrl.pop ? adv(rd_reg) : rd_reg;
            wr_next = ctrl.push ? wr_adv : wr_reg;
        end
    end

    always_comb
    begin
        stat.empty      = (rd_reg == wr_reg);
        stat.full       = (wr_adv == rd_reg);
        stat.empty_next = (rd_next == wr_next);
        stat.head       = head_reg;
        if (wr_next >= rd_next)
            stat.fill_next = FILL_W'(wr_next - rd_next);
        else
            stat.fill_next = FILL_W'(DEPTH) + FILL_W'(wr_next) - FILL_W'(rd_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[wr_reg] <= ctrl.push_data;
    end

    // Prefetch the word at the next read position; forward a word written there now.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (wr_reg == rd_next))
            head_reg <= ctrl.push_data;
        else
            head_reg <= mem[rd_next];
    end

endmodule

// ----- design/uart_tx_rx_ring_buffers.sv -----
`timescale 1ns / 1ps
// Transmit and receive byte rings in front of a UART.
// in_ch carries one operation per word (send, get, transmitter ready,
// byte received, flush) together with the hardware status bits sampled
// by the caller; out_ch returns one result word per operation with the
// delivered byte, the byte to write to the line, the drop flag, the
// transmit interrupt request and both fill counts.
// The configuration port writes tx_enable (index 0) and rx_enable
// (index 1); the user must do so only while no operation is in flight,
// which the block itself does not enforce. The result word is
// registered and appears in the cycle after acceptance; one operation
// is accepted per cycle while out_ch is not stalled. Each ring keeps
// its head byte prefetched from its memory, so a pop needs no memory read.
// Each ring holds DEPTH-1 bytes. Reset empties both rings and clears both
// enables; memory contents are not cleared and need no clearing pass.
// While the receiver on out_ch holds ready low, the result word stays in
// the output register and in_ch ready drops until it is taken.
module uart_tx_rx_ring_buffers #(
    parameter int TX_DEPTH = uart_trb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = uart_trb_pkg::RX_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [uart_trb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uart_trb_pkg::CFG_DATA_W-1:0]   cfg_data,
    uart_trb_in_if.sink                           in_ch,
    uart_trb_out_if.source                        out_ch
);
    import uart_trb_pkg::*;

    logic       tx_enable_reg;
    logic       rx_enable_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  res;
    logic       in_ready;
    logic       accept;
    ring_ctrl_t tx_ctrl;
    ring_ctrl_t rx_ctrl;
    ring_stat_t tx_stat;
    ring_stat_t rx_stat;
    logic       tx_extra;
    logic       rx_extra;
    logic [FILL_W:0] tx_n;
    logic [FILL_W:0] rx_n;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [FILL_W:0] n);
        return (n > (FILL_W + 1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : n[COUNT_W-1:0];
    endfunction

    uart_trb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .stat  (tx_stat)
    );

    uart_trb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .stat  (rx_stat)
    );

    assign in_ready     = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    always_comb
    begin
        res     = '0;
        res.accepted = 1'b1;
        tx_ctrl = '0;
        rx_ctrl = '0;
        tx_ctrl.push_data = in_ch.item.data;
        rx_ctrl.push_data = in_ch.item.data;

        if (accept)
        begin
            case (in_ch.item.opcode)
                OP_SEND:
                begin
                    if (tx_stat.empty && tx_enable_reg && in_ch.item.hw_tx_ready)
                    begin
                        res.line_write = 1'b1;
                        res.line_byte  = in_ch.item.data;
                    end
                    else if (tx_stat.full)
                        res.accepted = 1'b0;
                    else
                        tx_ctrl.push = 1'b1;
                end
                OP_GET:
                begin
                    if (!rx_stat.empty)
                    begin
                        res.read_valid = 1'b1;
                        res.read_data  = rx_stat.head;
                        rx_ctrl.pop    = 1'b1;
                    end
                    else if (rx_enable_reg && in_ch.item.hw_rx_ready)
                    begin
                        res.read_valid  = 1'b1;
                        res.read_data   = in_ch.item.hw_rx_byte;
                        res.hw_rx_taken = 1'b1;
                    end
                end
                OP_TX_READY:
                begin
                    if (tx_enable_reg && !tx_stat.empty)
                    begin
                        res.line_write = 1'b1;
                        res.line_byte  = tx_stat.head;
                        tx_ctrl.pop    = 1'b1;
                    end
                end
                OP_RX_BYTE:
                begin
                    if (rx_enable_reg)
                    begin
                        if (rx_stat.full)
                            res.rx_dropped = 1'b1;
                        else
                            rx_ctrl.push = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    tx_ctrl.clear = 1'b1;
                    rx_ctrl.clear = 1'b1;
                end
                default:
                begin
                    res.accepted = 1'b1;
                end
            endcase
        end

        // Counts include the byte still held in the hardware register.
        tx_extra = tx_enable_reg && (!in_ch.item.hw_tx_ready || res.line_write);
        rx_extra = rx_enable_reg && in_ch.item.hw_rx_ready && !res.hw_rx_taken;
        tx_n = {1'b0, tx_stat.fill_next} + (FILL_W + 1)'(tx_extra);
        rx_n = {1'b0, rx_stat.fill_next} + (FILL_W + 1)'(rx_extra);

        res.tx_irq_request = tx_enable_reg && !tx_stat.empty_next;
        res.tx_count       = sat_count(tx_n);
        res.rx_count       = sat_count(rx_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_enable_reg <= 1'b0;
            rx_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TX_ENABLE: tx_enable_reg <= cfg_data[0];
                CFG_RX_ENABLE: rx_enable_reg <= cfg_data[0];
                default:       tx_enable_reg <= tx_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Hold the result word until it is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
            out_item_reg <= res;
    end

endmodule

// ----- design/uart_trb_checker.sv -----
`timescale 1ns / 1ps
`include "uart_tx_rx_ring_buffers_macros.svh"

module uart_trb_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input uart_trb_pkg::out_item_t out_item
);

    logic stalled;
    logic bytes_idle_zero;

    assign stalled         = out_valid && !out_ready;
    // Byte fields stay zero unless their strobe is set.
    assign bytes_idle_zero = (out_item.read_valid || out_item.read_data == 8'd0) &&
                             (out_item.line_write || out_item.line_byte == 8'd0);

    `TRB_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

    `TRB_ASSERT_IMPLY(a_no_take_when_stalled, clk, rst_n, stalled, !in_ready)

    `TRB_ASSERT_NEXT(a_stalled_word_holds, clk, rst_n, stalled, out_valid && $stable(out_item))

    `TRB_ASSERT_IMPLY(a_idle_bytes_zero, clk, rst_n, out_valid, bytes_idle_zero)

endmodule

bind uart_tx_rx_ring_buffers uart_trb_checker u_uart_trb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
);
